// ===== rtl/core/tlc_pkg.sv =====
// Shared constants and types for the three-level exclusive cache.
`default_nettype none
package tlc_pkg;
    localparam int unsigned L1_LINES_DEF      = 8;
    localparam int unsigned L2_LINES_DEF      = 16;
    localparam int unsigned L3_LINES_DEF      = 32;
    localparam int unsigned MEMORY_BLOCKS_DEF = 1024;

    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned STAMP_W = 32;
    localparam int unsigned COST_W  = 11;

    localparam logic [1:0] LVL_L1  = 2'd0;
    localparam logic [1:0] LVL_L2  = 2'd1;
    localparam logic [1:0] LVL_L3  = 2'd2;
    localparam logic [1:0] LVL_MEM = 2'd3;

    // One cache line as stored in the level memories.
    typedef struct packed {
        logic               valid;
        logic [ADDR_W-1:0]  addr;
        logic               dirty;
        logic [STAMP_W-1:0] stamp;
    } line_t;

    // Result of a level scan.
    typedef struct packed {
        logic hit;
    } scan_flags_t;
endpackage
`default_nettype wire

// ===== rtl/core/tlc_level.sv =====
// One cache level: line memory with a sequential search and victim scan.
`default_nettype none
module tlc_level #(
    parameter int unsigned LINES = 8
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         scan_start,
    input  wire  [tlc_pkg::ADDR_W-1:0]  scan_addr,
    output logic                        scan_done,
    output logic                        scan_hit,
    output logic [$clog2(LINES+1)-1:0]  hit_slot,
    output logic [$clog2(LINES+1)-1:0]  victim_slot,
    input  wire  [$clog2(LINES+1)-1:0]  rd_slot,
    output tlc_pkg::line_t              rd_line,
    input  wire                         wr_en,
    input  wire  [$clog2(LINES+1)-1:0]  wr_slot,
    input  wire  tlc_pkg::line_t        wr_line
);
    import tlc_pkg::*;

    localparam int unsigned IW = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int unsigned CW = $clog2(LINES+1);
    localparam logic [CW-1:0] LAST = CW'(LINES - 1);

    line_t             mem [LINES];
    logic [LINES-1:0]  valid_reg;
    line_t             q_reg;
    logic              q_valid_reg;

    logic              busy_reg, rd_pend_reg;
    logic [CW-1:0]     idx_reg, ridx_reg;
    logic              hit_reg;
    logic [CW-1:0]     hit_slot_reg, best_reg;
    logic [STAMP_W-1:0] best_stamp_reg;
    logic              done_reg;

    logic [CW-1:0]     rport_slot;
    logic [IW-1:0]     rport_idx, wport_idx;
    line_t             cur;

    assign rport_slot = busy_reg ? idx_reg : rd_slot;
    assign rport_idx  = rport_slot[IW-1:0];
    assign wport_idx  = wr_slot[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wport_idx] <= wr_line;
        end
        q_reg <= mem[rport_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            q_valid_reg <= valid_reg[rport_idx];
            if (wr_en)
            begin
                valid_reg[wport_idx] <= 1'b1;
            end
        end
    end

    // Unwritten entries read as the reset line.
    always_comb
    begin
        cur = q_reg;
        if (!q_valid_reg)
        begin
            cur = '0;
        end
    end
    assign rd_line = cur;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            rd_pend_reg    <= 1'b0;
            idx_reg        <= '0;
            ridx_reg       <= '0;
            hit_reg        <= 1'b0;
            hit_slot_reg   <= '0;
            best_reg       <= '0;
            best_stamp_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (scan_start)
            begin
                busy_reg    <= 1'b1;
                rd_pend_reg <= 1'b0;
                idx_reg     <= '0;
                hit_reg     <= 1'b0;
                best_reg    <= '0;
            end
            else
            begin
                if (busy_reg)
                begin
                    rd_pend_reg <= 1'b1;
                    ridx_reg    <= idx_reg;
                    if (idx_reg == LAST)
                    begin
                        busy_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                else
                begin
                    rd_pend_reg <= 1'b0;
                end
                if (rd_pend_reg)
                begin
                    if (cur.valid && cur.addr == scan_addr && !hit_reg)
                    begin
                        hit_reg      <= 1'b1;
                        hit_slot_reg <= ridx_reg;
                    end
                    if (ridx_reg == '0)
                    begin
                        best_stamp_reg <= cur.stamp;
                    end
                    else if (!cur.valid || cur.stamp < best_stamp_reg)
                    begin
                        best_reg       <= ridx_reg;
                        best_stamp_reg <= cur.stamp;
                    end
                    if (ridx_reg == LAST)
                    begin
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    // Slot 0 empty: it stays the choice unless a later slot is also empty.
    assign scan_done   = done_reg;
    assign scan_hit    = hit_reg;
    assign hit_slot    = hit_slot_reg;
    assign victim_slot = best_reg;
endmodule
`default_nettype wire

// ===== rtl/core/three_level_exclusive_lru_cache.sv =====
// Top level of the three-level exclusive cache; the victim is the line with the oldest stamp.
//
// Input channel s_axis: one word per access, tdata = {is_write, block_address}.
// Output channel m_axis: one word per access, tdata holds hit_level, l1_slot,
// access_cost, writeback_valid, writeback_block from the lowest bit up.
// Each level keeps its lines in a synchronous memory with one read port and
// one write port; every scan reads all lines of a level in turn, finding a
// hit and the victim at once. An access scans L1, then L2 on an L1 miss and
// L3 on an L2 miss, then reads and rewrites the lines that move. One
// access is in flight at a time, and the block returns to idle after each
// result before it takes the next access.
// The result sits in an output register; the next word is taken while it
// waits, but its result is held until the previous one has gone.
// Reset empties all levels at once (valid bits) and clears the access clock.
// A stalled receiver holds the output register, and the next access waits
// with its result until the register is free.
`default_nettype none
module three_level_exclusive_lru_cache #(
    parameter int unsigned L1_LINES      = tlc_pkg::L1_LINES_DEF,
    parameter int unsigned L2_LINES      = tlc_pkg::L2_LINES_DEF,
    parameter int unsigned L3_LINES      = tlc_pkg::L3_LINES_DEF,
    parameter int unsigned MEMORY_BLOCKS = tlc_pkg::MEMORY_BLOCKS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,  // block_address[9:0], is_write[10]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // hit_level[1:0], l1_slot[4:2],
                                       // access_cost[15:5], writeback_valid[16],
                                       // writeback_block[26:17]
);
    import tlc_pkg::*;

    localparam int unsigned C1 = $clog2(L1_LINES+1);
    localparam int unsigned C2 = $clog2(L2_LINES+1);
    localparam int unsigned C3 = $clog2(L3_LINES+1);
    localparam int unsigned CS = L1_LINES + L2_LINES + L3_LINES + MEMORY_BLOCKS;
    localparam logic [COST_W-1:0] K1 = COST_W'((L1_LINES > 2047) ? 2047 : L1_LINES);
    localparam logic [COST_W-1:0] K2 =
        COST_W'((L1_LINES + L2_LINES > 2047) ? 2047 : L1_LINES + L2_LINES);
    localparam logic [COST_W-1:0] K3 =
        COST_W'((L1_LINES + L2_LINES + L3_LINES > 2047) ? 2047
                : L1_LINES + L2_LINES + L3_LINES);
    localparam logic [COST_W-1:0] K4 = COST_W'((CS > 2047) ? 2047 : CS);

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_S1    = 12'b000000000010,
        ST_S2    = 12'b000000000100,
        ST_S3    = 12'b000000001000,
        ST_MRD   = 12'b000000010000,
        ST_MFIX  = 12'b000000100000,
        ST_L3RD  = 12'b000001000000,
        ST_L3SW  = 12'b000010000000,
        ST_L2RD  = 12'b000100000000,
        ST_L2SW  = 12'b001000000000,
        ST_WR1   = 12'b010000000000,
        ST_OUT   = 12'b100000000000
    } state_t;

    state_t             state_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic               wr_reg;
    logic [STAMP_W-1:0] clock_reg;
    logic [1:0]         level_reg;
    logic [COST_W-1:0]  cost_reg;
    logic               wbv_reg;
    logic [ADDR_W-1:0]  wbb_reg;
    logic [C1-1:0]      slot1_reg;
    logic [C2-1:0]      slot2_reg;
    logic [C3-1:0]      slot3_reg;
    line_t              up_reg;     // line travelling upward
    logic               ov_reg;
    logic [31:0]        obuf_reg;

    logic st1, st2, st3;
    logic d1, d2, d3, h1, h2, h3;
    logic [C1-1:0] hs1, vs1, rs1, ws1;
    logic [C2-1:0] hs2, vs2, rs2, ws2;
    logic [C3-1:0] hs3, vs3, rs3, ws3;
    line_t rl1, rl2, rl3, wl1, wl2, wl3;
    logic we1, we2, we3;

    tlc_level #(.LINES(L1_LINES)) u_l1 (
        .clk(clk), .rst_n(rst_n), .scan_start(st1), .scan_addr(addr_reg),
        .scan_done(d1), .scan_hit(h1), .hit_slot(hs1), .victim_slot(vs1),
        .rd_slot(rs1), .rd_line(rl1), .wr_en(we1), .wr_slot(ws1), .wr_line(wl1));
    tlc_level #(.LINES(L2_LINES)) u_l2 (
        .clk(clk), .rst_n(rst_n), .scan_start(st2), .scan_addr(addr_reg),
        .scan_done(d2), .scan_hit(h2), .hit_slot(hs2), .victim_slot(vs2),
        .rd_slot(rs2), .rd_line(rl2), .wr_en(we2), .wr_slot(ws2), .wr_line(wl2));
    tlc_level #(.LINES(L3_LINES)) u_l3 (
        .clk(clk), .rst_n(rst_n), .scan_start(st3), .scan_addr(addr_reg),
        .scan_done(d3), .scan_hit(h3), .hit_slot(hs3), .victim_slot(vs3),
        .rd_slot(rs3), .rd_line(rl3), .wr_en(we3), .wr_slot(ws3), .wr_line(wl3));

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = obuf_reg;

    logic [STAMP_W-1:0] clk_inc;
    assign clk_inc = clock_reg + 1'b1;

    always_comb
    begin
        st1 = 1'b0; st2 = 1'b0; st3 = 1'b0;
        we1 = 1'b0; we2 = 1'b0; we3 = 1'b0;
        rs1 = slot1_reg; rs2 = slot2_reg; rs3 = slot3_reg;
        ws1 = slot1_reg; ws2 = slot2_reg; ws3 = slot3_reg;
        wl1 = up_reg; wl2 = up_reg; wl3 = up_reg;
        unique case (state_reg)
            ST_IDLE: st1 = s_axis_tvalid;
            ST_S1:   st2 = d1 && !h1;
            ST_S2:
            begin
                st3 = d2 && !h2;
                rs2 = h2 ? hs2 : vs2;
            end
            ST_S3:
            begin
                rs3 = h3 ? hs3 : vs3;
            end
            ST_MRD:  ;
            ST_MFIX: ;
            ST_L3RD: rs2 = slot2_reg;
            ST_L3SW:
            begin
                // L2 victim down into the L3 slot; the block itself travels on in up_reg
                we3 = 1'b1;
                wl3 = rl2;
            end
            ST_L2RD: ;
            ST_L2SW:
            begin
                we2 = 1'b1;
                wl2 = rl1;
            end
            ST_WR1:
            begin
                // an L1 hit rewrites its own line, otherwise the arriving block
                we1 = 1'b1;
                wl1 = (level_reg == LVL_L1) ? rl1 : up_reg;
                wl1.dirty = wl1.dirty | wr_reg;
            end
            ST_OUT:  ;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            clock_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            if (ov_reg && m_axis_tready && state_reg != ST_OUT)
            begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        addr_reg  <= s_axis_tdata[ADDR_W-1:0];
                        wr_reg    <= s_axis_tdata[ADDR_W];
                        wbv_reg   <= 1'b0;
                        wbb_reg   <= '0;
                        state_reg <= ST_S1;
                    end
                end
                ST_S1:
                begin
                    if (d1)
                    begin
                        slot1_reg <= h1 ? hs1 : vs1;
                        if (h1)
                        begin
                            level_reg <= LVL_L1;
                            cost_reg  <= K1;
                            state_reg <= ST_L2RD;
                        end
                        else
                        begin
                            state_reg <= ST_S2;
                        end
                    end
                end
                ST_S2:
                begin
                    if (d2)
                    begin
                        slot2_reg <= h2 ? hs2 : vs2;
                        if (h2)
                        begin
                            level_reg <= LVL_L2;
                            cost_reg  <= K2;
                            state_reg <= ST_L2RD;
                        end
                        else
                        begin
                            state_reg <= ST_S3;
                        end
                    end
                end
                ST_S3:
                begin
                    if (d3)
                    begin
                        slot3_reg <= h3 ? hs3 : vs3;
                        level_reg <= h3 ? LVL_L3 : LVL_MEM;
                        cost_reg  <= h3 ? K3 : K4;
                        state_reg <= ST_MRD;
                    end
                end
                ST_MRD:
                begin
                    // L3 line at slot3 is now on rl3
                    state_reg <= ST_MFIX;
                end
                ST_MFIX:
                begin
                    if (level_reg == LVL_MEM)
                    begin
                        wbv_reg <= rl3.valid && rl3.dirty;
                        wbb_reg <= (rl3.valid && rl3.dirty) ? rl3.addr : '0;
                        up_reg  <= '{valid: 1'b1, addr: addr_reg, dirty: 1'b0,
                                     stamp: '0};
                    end
                    else
                    begin
                        up_reg <= rl3;
                    end
                    state_reg <= ST_L3RD;
                end
                ST_L3RD: state_reg <= ST_L3SW;
                ST_L3SW: state_reg <= ST_L2RD;
                ST_L2RD:
                begin
                    if (level_reg == LVL_L1)
                    begin
                        state_reg <= ST_WR1;
                    end
                    else
                    begin
                        if (level_reg == LVL_L2)
                        begin
                            up_reg <= rl2;
                        end
                        state_reg <= ST_L2SW;
                    end
                end
                ST_L2SW:
                begin
                    // rl1 and rl2 valid after ST_L2RD read
                    up_reg.stamp <= clk_inc;
                    clock_reg    <= clk_inc;
                    state_reg    <= ST_WR1;
                end
                ST_WR1:
                begin
                    state_reg <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (!ov_reg || m_axis_tready)
                    begin
                        ov_reg    <= 1'b1;
                        obuf_reg  <= {5'd0, wbb_reg, wbv_reg, cost_reg,
                                      3'(slot1_reg), level_reg};
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ===== verif/three_level_exclusive_lru_cache_checker.sv =====
// Checker for the three-level cache: mirrors the level contents and compares each result word.
module three_level_exclusive_lru_cache_checker
    import tlc_pkg::*;
(
    input  wire        clk,
    input  wire        rst_n,
    input  wire        s_axis_tvalid,
    input  wire        s_axis_tready,
    input  wire [15:0] s_axis_tdata,
    input  wire        m_axis_tvalid,
    input  wire        m_axis_tready,
    input  wire [31:0] m_axis_tdata,
    output int         fail_count,
    output int         pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N1 = L1_LINES_DEF;
    localparam int N2 = L2_LINES_DEF;
    localparam int N3 = L3_LINES_DEF;

    typedef struct packed {
        logic [9:0]  wb_block;
        logic        wb_valid;
        logic [10:0] cost;
        logic [2:0]  slot;
        logic [1:0]  level;
    } access_result_t;

    line_t l1_mirror [N1];
    line_t l2_mirror [N2];
    line_t l3_mirror [N3];
    logic [31:0] clock_mirror;
    access_result_t expected_results [$];

    assign pending_count = expected_results.size();

    // last empty slot wins, else first slot with the lowest stamp
    function automatic int victim_of(input line_t lines [], input int n);
        int best;
        best = 0;
        for (int i = 0; i < n; i++)
            if (!lines[i].valid || lines[i].stamp < lines[best].stamp)
                best = i;
        return best;
    endfunction

    function automatic int find_block(input line_t lines [], input int n,
                                      input logic [9:0] blk);
        for (int i = 0; i < n; i++)
            if (lines[i].valid && lines[i].addr == blk)
                return i;
        return -1;
    endfunction

    function automatic int lift_from_l2(input int s2);
        line_t a [];
        line_t tmp;
        int v;
        a = new[N1];
        foreach (l1_mirror[i]) a[i] = l1_mirror[i];
        v = victim_of(a, N1);
        tmp = l1_mirror[v];
        l1_mirror[v] = l2_mirror[s2];
        l2_mirror[s2] = tmp;
        clock_mirror = clock_mirror + 1;
        l1_mirror[v].stamp = clock_mirror;
        return v;
    endfunction

    function automatic int lift_from_l3(input int s3);
        line_t a [];
        line_t tmp;
        int v;
        a = new[N2];
        foreach (l2_mirror[i]) a[i] = l2_mirror[i];
        v = victim_of(a, N2);
        tmp = l2_mirror[v];
        l2_mirror[v] = l3_mirror[s3];
        l3_mirror[s3] = tmp;
        return v;
    endfunction

    function automatic access_result_t predict_access(input logic [9:0] blk,
                                                      input logic wr);
        access_result_t r;
        line_t a [];
        int hit;
        int slot;
        int v3;
        int unsigned cost;
        r = '0;
        cost = N1;
        a = new[N1];
        foreach (l1_mirror[i]) a[i] = l1_mirror[i];
        hit = find_block(a, N1, blk);
        if (hit >= 0) begin
            r.level = LVL_L1;
            slot = hit;
        end
        else begin
            cost += N2;
            a = new[N2];
            foreach (l2_mirror[i]) a[i] = l2_mirror[i];
            hit = find_block(a, N2, blk);
            if (hit >= 0) begin
                r.level = LVL_L2;
                slot = lift_from_l2(hit);
            end
            else begin
                cost += N3;
                a = new[N3];
                foreach (l3_mirror[i]) a[i] = l3_mirror[i];
                hit = find_block(a, N3, blk);
                if (hit >= 0) begin
                    r.level = LVL_L3;
                    slot = lift_from_l2(lift_from_l3(hit));
                end
                else begin
                    cost += MEMORY_BLOCKS_DEF;
                    r.level = LVL_MEM;
                    v3 = victim_of(a, N3);
                    if (l3_mirror[v3].valid && l3_mirror[v3].dirty) begin
                        r.wb_valid = 1'b1;
                        r.wb_block = l3_mirror[v3].addr;
                    end
                    l3_mirror[v3].valid = 1'b1;
                    l3_mirror[v3].addr  = blk;
                    l3_mirror[v3].dirty = 1'b0;
                    l3_mirror[v3].stamp = '0;
                    slot = lift_from_l2(lift_from_l3(v3));
                end
            end
        end
        if (wr)
            l1_mirror[slot].dirty = 1'b1;
        r.slot = slot[2:0];
        r.cost = (cost > 2047) ? 11'd2047 : cost[10:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        access_result_t e;
        access_result_t got;
        if (!rst_n) begin
            foreach (l1_mirror[i]) l1_mirror[i] = '0;
            foreach (l2_mirror[i]) l2_mirror[i] = '0;
            foreach (l3_mirror[i]) l3_mirror[i] = '0;
            clock_mirror = '0;
            expected_results.delete();
            fail_count <= 0;
        end
        else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[26:0];
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else begin
                    e = expected_results.pop_front();
                    if (got != e) begin
                        fail_count <= fail_count + 1;
                        if (got.level != e.level)
                            $error("hit_level exp %0d got %0d", e.level, got.level);
                        if (got.slot != e.slot)
                            $error("l1_slot exp %0d got %0d", e.slot, got.slot);
                        if (got.cost != e.cost)
                            $error("access_cost exp %0d got %0d", e.cost, got.cost);
                        if (got.wb_valid != e.wb_valid)
                            $error("writeback_valid exp %0d got %0d",
                                   e.wb_valid, got.wb_valid);
                        if (got.wb_block != e.wb_block)
                            $error("writeback_block exp %0d got %0d",
                                   e.wb_block, got.wb_block);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(
                    predict_access(s_axis_tdata[9:0], s_axis_tdata[10]));
        end
    end
endmodule

// ===== verif/three_level_exclusive_lru_cache_test.sv =====
// Testbench top: drives access words into the cache and gives the verdict.
module three_level_exclusive_lru_cache_test;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    int          fail_count;
    int          pending_count;
    bit          calm;

    three_level_exclusive_lru_cache uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    three_level_exclusive_lru_cache_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver stalls at random with a probability of 12 percent, except in the calm stretch
    always @(posedge clk)
        m_axis_tready <= calm || ($urandom_range(99) >= 12);

    // present one word; a gap is taken only before raising tvalid
    task automatic send_word(input logic [9:0] blk, input logic wr);
        while (!calm && $urandom_range(99) < 12)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'd0, wr, blk};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    logic [9:0] recent [$];

    function automatic logic [9:0] pick_block();
        int r;
        r = $urandom_range(99);
        // mostly reuse of a recent working set so all levels see hits
        if (r < 70 && recent.size() > 0)
            return recent[$urandom_range(recent.size() - 1)];
        else if (r < 85)
            return 10'($urandom_range(79));
        return 10'($urandom);
    endfunction

    initial
    begin
        logic [9:0] b;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: address extremes, L1 hit, write to make dirty lines
        send_word(10'd0, 1'b0);
        send_word(10'd1023, 1'b1);
        send_word(10'd0, 1'b1);
        send_word(10'd1023, 1'b0);
        send_word(10'h2AA, 1'b1);
        send_word(10'h155, 1'b0);
        // fill past L1+L2+L3 capacity with dirty blocks to force write-backs
        for (int i = 0; i < 60; i++)
            send_word(10'(100 + i), 1'b1);
        // revisit: blocks now spread over L1, L2, L3 and memory
        send_word(10'd130, 1'b0);
        send_word(10'd150, 1'b0);
        send_word(10'd100, 1'b1);
        send_word(10'd159, 1'b0);

        for (int n = 0; n < 950; n++) begin
            calm = (n >= 400 && n < 550);
            b = pick_block();
            recent.push_back(b);
            if (recent.size() > 48)
                void'(recent.pop_front());
            send_word(b, 1'($urandom));
        end
        s_axis_tvalid <= 1'b0;
        calm = 1'b0;

        while (pending_count != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
